FILE: src/bdr_pkg.sv
package bdr_pkg;

    // Item kinds carried in the input tuser field.
    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_SET_SPEED   = 3'd1,
        OP_SET_INCLINE = 3'd2,
        OP_SET_DIR     = 3'd3,
        OP_START       = 3'd4,
        OP_STOP        = 3'd5,
        OP_ESTOP       = 3'd6,
        OP_RESET_ESTOP = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_RANGE     = 2'd1,
        ERR_MOVING    = 2'd2,
        ERR_EMERGENCY = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_STOPPED   = 2'd0,
        ST_RUNNING   = 2'd1,
        ST_STOPPING  = 2'd2,
        ST_EMERGENCY = 2'd3
    } run_state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_SPEED    = 2'd0;
    localparam logic [1:0] REG_MAX_INCLINE  = 2'd1;
    localparam logic [1:0] REG_SPEED_RATE   = 2'd2;
    localparam logic [1:0] REG_INCLINE_RATE = 2'd3;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned VAL_W = 16;
    localparam int unsigned DT_W  = 8;

    localparam logic [CFG_W-1:0] MAX_SPEED_RST    = 16'd2000;
    localparam logic [CFG_W-1:0] MAX_INCLINE_RST  = 16'd1500;
    localparam logic [CFG_W-1:0] SPEED_RATE_RST   = 16'd100;
    localparam logic [CFG_W-1:0] INCLINE_RATE_RST = 16'd100;

    // Longest tick honored, in milliseconds.
    localparam logic [9:0] MAX_TICK_MS = 10'd250;

    // Direction may change only at or below 0.20 km/h; a stopping belt
    // at or below 0.01 km/h snaps to zero.
    localparam logic [VAL_W-1:0] SPEED_DIR_LIMIT = 16'd20;
    localparam logic [VAL_W-1:0] SPEED_SNAP      = 16'd1;

    localparam logic DIR_FWD = 1'b0;

    // rate * dt fits 24 bits. Division by 1000 is a multiplication by
    // ceil(2^35 / 1000) followed by a 35 bit right shift, exact for any
    // 24 bit dividend. The quotient fits the upper 15 bits of the product.
    localparam int unsigned PROD_W    = CFG_W + DT_W;
    localparam int unsigned RECIP_W   = 26;
    localparam int unsigned QFULL_W   = PROD_W + RECIP_W;
    localparam int unsigned DIV_SHIFT = 35;
    localparam int unsigned QUOT_W    = QFULL_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] DIV_MUL = 26'd34359739;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic             dir;
    } item_t;

    typedef struct packed {
        item_t            item;
        logic [VAL_W-1:0] speed_delta;
        logic [VAL_W-1:0] incline_delta;
    } step_item_t;

    typedef struct packed {
        logic             accepted;
        err_t             error_code;
        run_state_t       run_state;
        logic [VAL_W-1:0] speed;
        logic [VAL_W-1:0] incline;
        logic             dir;
    } result_t;

endpackage

FILE: src/bdr_step_unit.sv
// Two stages that turn a tick length into ramp steps: the first multiplies
// rate by the clamped tick, the second divides by 1000 through a reciprocal.
module bdr_step_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [bdr_pkg::CFG_W-1:0]  speed_rate,
    input  logic [bdr_pkg::CFG_W-1:0]  incline_rate,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bdr_pkg::item_t             in_item,
    input  logic [bdr_pkg::DT_W-1:0]   in_dt,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bdr_pkg::step_item_t        out_item
);

    logic                          prod_valid_reg;
    bdr_pkg::item_t                prod_item_reg;
    logic [bdr_pkg::PROD_W-1:0]    prod_speed_reg;
    logic [bdr_pkg::PROD_W-1:0]    prod_incline_reg;
    logic [bdr_pkg::PROD_W-1:0]    prod_speed_next;
    logic [bdr_pkg::PROD_W-1:0]    prod_incline_next;

    logic                          step_valid_reg;
    bdr_pkg::step_item_t           step_item_reg;
    bdr_pkg::step_item_t           step_item_next;

    logic [bdr_pkg::DT_W-1:0]      dt_clamped;
    logic [bdr_pkg::QFULL_W-1:0]   q_speed;
    logic [bdr_pkg::QFULL_W-1:0]   q_incline;
    logic                          load_prod;
    logic                          load_step;

    assign load_step = prod_valid_reg && (!step_valid_reg || out_ready);
    assign in_ready  = !prod_valid_reg || load_step;
    assign load_prod = in_valid && in_ready;

    // A tick longer than the limit counts as the limit.
    assign dt_clamped = ({2'b00, in_dt} > bdr_pkg::MAX_TICK_MS) ?
                        bdr_pkg::MAX_TICK_MS[bdr_pkg::DT_W-1:0] : in_dt;

    assign prod_speed_next   = {{bdr_pkg::DT_W{1'b0}}, speed_rate} *
                               {{bdr_pkg::CFG_W{1'b0}}, dt_clamped};
    assign prod_incline_next = {{bdr_pkg::DT_W{1'b0}}, incline_rate} *
                               {{bdr_pkg::CFG_W{1'b0}}, dt_clamped};

    assign q_speed   = {{bdr_pkg::RECIP_W{1'b0}}, prod_speed_reg} *
                       {{bdr_pkg::PROD_W{1'b0}}, bdr_pkg::DIV_MUL};
    assign q_incline = {{bdr_pkg::RECIP_W{1'b0}}, prod_incline_reg} *
                       {{bdr_pkg::PROD_W{1'b0}}, bdr_pkg::DIV_MUL};

    always_comb begin
        step_item_next.item          = prod_item_reg;
        step_item_next.speed_delta   =
            {{(bdr_pkg::VAL_W - bdr_pkg::QUOT_W){1'b0}},
             q_speed[bdr_pkg::QFULL_W-1:bdr_pkg::DIV_SHIFT]};
        step_item_next.incline_delta =
            {{(bdr_pkg::VAL_W - bdr_pkg::QUOT_W){1'b0}},
             q_incline[bdr_pkg::QFULL_W-1:bdr_pkg::DIV_SHIFT]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            step_valid_reg <= 1'b0;
        end else begin
            if (load_prod) begin
                prod_valid_reg <= 1'b1;
            end else if (load_step) begin
                prod_valid_reg <= 1'b0;
            end
            if (load_step) begin
                step_valid_reg <= 1'b1;
            end else if (out_ready) begin
                step_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_prod) begin
            prod_item_reg    <= in_item;
            prod_speed_reg   <= prod_speed_next;
            prod_incline_reg <= prod_incline_next;
        end
        if (load_step) begin
            step_item_reg <= step_item_next;
        end
    end

    assign out_valid = step_valid_reg;
    assign out_item  = step_item_reg;

endmodule

FILE: src/bdr_core.sv
// Run state, speed, incline and direction, updated once per item, and the
// result register that holds the beat for the output side.
module bdr_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [bdr_pkg::CFG_W-1:0]  max_speed,
    input  logic [bdr_pkg::CFG_W-1:0]  max_incline,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bdr_pkg::step_item_t        in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bdr_pkg::result_t           out_result
);

    bdr_pkg::run_state_t           run_state_reg;
    bdr_pkg::run_state_t           run_state_next;
    logic [bdr_pkg::VAL_W-1:0]     speed_now_reg;
    logic [bdr_pkg::VAL_W-1:0]     speed_now_next;
    logic [bdr_pkg::VAL_W-1:0]     speed_goal_reg;
    logic [bdr_pkg::VAL_W-1:0]     speed_goal_next;
    logic [bdr_pkg::VAL_W-1:0]     incline_now_reg;
    logic [bdr_pkg::VAL_W-1:0]     incline_now_next;
    logic [bdr_pkg::VAL_W-1:0]     incline_goal_reg;
    logic [bdr_pkg::VAL_W-1:0]     incline_goal_next;
    logic                          belt_dir_reg;
    logic                          belt_dir_next;
    logic                          result_valid_reg;
    bdr_pkg::result_t              result_reg;
    bdr_pkg::result_t              result_next;
    logic                          cmd_ok;
    bdr_pkg::err_t                 cmd_err;
    logic [bdr_pkg::VAL_W-1:0]     speed_ramped;
    logic                          load;

    // Moves cur toward goal by at most step without passing it.
    function automatic logic [bdr_pkg::VAL_W-1:0] move_toward(
        input logic [bdr_pkg::VAL_W-1:0] cur,
        input logic [bdr_pkg::VAL_W-1:0] goal,
        input logic [bdr_pkg::VAL_W-1:0] step
    );
        logic [bdr_pkg::VAL_W:0]   sum;
        logic [bdr_pkg::VAL_W-1:0] gap;
        logic [bdr_pkg::VAL_W-1:0] res;
        sum = {1'b0, cur} + {1'b0, step};
        gap = cur - goal;
        if (cur < goal) begin
            res = (sum > {1'b0, goal}) ? goal : sum[bdr_pkg::VAL_W-1:0];
        end else if (cur > goal) begin
            res = (step >= gap) ? goal : cur - step;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    assign in_ready = !result_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign speed_ramped = move_toward(speed_now_reg, speed_goal_reg,
                                      in_item.speed_delta);

    always_comb begin
        run_state_next    = run_state_reg;
        speed_now_next    = speed_now_reg;
        speed_goal_next   = speed_goal_reg;
        incline_now_next  = incline_now_reg;
        incline_goal_next = incline_goal_reg;
        belt_dir_next     = belt_dir_reg;
        cmd_ok            = 1'b1;
        cmd_err           = bdr_pkg::ERR_NONE;

        unique case (in_item.item.op)
            bdr_pkg::OP_TICK: begin
                if (run_state_reg == bdr_pkg::ST_RUNNING ||
                    run_state_reg == bdr_pkg::ST_STOPPING) begin
                    speed_now_next = speed_ramped;
                    if (run_state_reg == bdr_pkg::ST_STOPPING &&
                        speed_ramped <= bdr_pkg::SPEED_SNAP) begin
                        speed_now_next = '0;
                        run_state_next = bdr_pkg::ST_STOPPED;
                    end
                end
                incline_now_next = move_toward(incline_now_reg, incline_goal_reg,
                                               in_item.incline_delta);
            end
            bdr_pkg::OP_SET_SPEED: begin
                if (in_item.item.value > max_speed) begin
                    cmd_ok  = 1'b0;
                    cmd_err = bdr_pkg::ERR_RANGE;
                end else begin
                    speed_goal_next = in_item.item.value;
                end
            end
            bdr_pkg::OP_SET_INCLINE: begin
                if (in_item.item.value > max_incline) begin
                    cmd_ok  = 1'b0;
                    cmd_err = bdr_pkg::ERR_RANGE;
                end else begin
                    incline_goal_next = in_item.item.value;
                end
            end
            bdr_pkg::OP_SET_DIR: begin
                if (speed_now_reg > bdr_pkg::SPEED_DIR_LIMIT) begin
                    cmd_ok  = 1'b0;
                    cmd_err = bdr_pkg::ERR_MOVING;
                end else begin
                    belt_dir_next = in_item.item.dir;
                end
            end
            bdr_pkg::OP_START: begin
                if (run_state_reg == bdr_pkg::ST_EMERGENCY) begin
                    cmd_ok  = 1'b0;
                    cmd_err = bdr_pkg::ERR_EMERGENCY;
                end else begin
                    run_state_next = bdr_pkg::ST_RUNNING;
                end
            end
            bdr_pkg::OP_STOP: begin
                if (run_state_reg != bdr_pkg::ST_EMERGENCY) begin
                    speed_goal_next = '0;
                    run_state_next  = (speed_now_reg > bdr_pkg::SPEED_SNAP) ?
                                      bdr_pkg::ST_STOPPING : bdr_pkg::ST_STOPPED;
                end
            end
            bdr_pkg::OP_ESTOP: begin
                speed_goal_next = '0;
                speed_now_next  = '0;
                run_state_next  = bdr_pkg::ST_EMERGENCY;
            end
            bdr_pkg::OP_RESET_ESTOP: begin
                if (run_state_reg == bdr_pkg::ST_EMERGENCY) begin
                    run_state_next = bdr_pkg::ST_STOPPED;
                end
            end
            default: begin
                run_state_next = run_state_reg;
            end
        endcase

        result_next.accepted   = cmd_ok;
        result_next.error_code = cmd_err;
        result_next.run_state  = run_state_next;
        result_next.speed      = speed_now_next;
        result_next.incline    = incline_now_next;
        result_next.dir        = belt_dir_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_state_reg    <= bdr_pkg::ST_STOPPED;
            speed_now_reg    <= '0;
            speed_goal_reg   <= '0;
            incline_now_reg  <= '0;
            incline_goal_reg <= '0;
            belt_dir_reg     <= bdr_pkg::DIR_FWD;
            result_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                run_state_reg    <= run_state_next;
                speed_now_reg    <= speed_now_next;
                speed_goal_reg   <= speed_goal_next;
                incline_now_reg  <= incline_now_next;
                incline_goal_reg <= incline_goal_next;
                belt_dir_reg     <= belt_dir_next;
                result_valid_reg <= 1'b1;
            end else if (out_ready) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = result_valid_reg;
    assign out_result = result_reg;

    // A refused command always carries a reason, an accepted one never does.
    a_accept_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid_reg |->
            (result_reg.accepted == (result_reg.error_code == bdr_pkg::ERR_NONE)))
        else $error("accepted flag and error code disagree");

    // The belt never moves in the emergency state.
    a_emergency_still: assert property (@(posedge aclk) disable iff (!aresetn)
        run_state_reg == bdr_pkg::ST_EMERGENCY |-> speed_now_reg == '0)
        else $error("belt speed nonzero in emergency state");

    // An emergency stop takes effect on the item that carries it.
    a_estop_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && load && in_item.item.op == bdr_pkg::OP_ESTOP |=>
            speed_now_reg == '0 && speed_goal_reg == '0 &&
            run_state_reg == bdr_pkg::ST_EMERGENCY)
        else $error("emergency stop did not stop the belt");

    // State moves only when an item is taken.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !load |=>
            $stable(run_state_reg) && $stable(speed_now_reg) &&
            $stable(incline_now_reg) && $stable(belt_dir_reg))
        else $error("belt state changed without an item");

endmodule

FILE: src/belt_drive_ramp_state_machine.sv
// Treadmill belt drive controller with slew-rate-limited speed and incline.
// Every input beat is a command or a tick, selected by s_tuser, and produces
// exactly one result beat that reports whether the command was taken, the
// reason for a refusal, and the run state, actual speed, actual incline and
// direction after the beat. A tick moves speed toward its target only while
// running or stopping, and incline in every state, by at most rate times the
// tick length (capped at 250 ms) divided by 1000, never past the target.
// The block takes one beat per clock cycle while m_tready does not hold the
// stages; each beat passes through the input register, the rate-times-tick
// multiply stage, the divide-by-1000 reciprocal stage and the result register
// that holds the state update. The run state and the ramps are updated as
// the result register loads, so consecutive beats need no spacing.
// Back-pressure on m_tready stalls the stages in turn; the input side keeps
// taking beats until every stage is full. Configuration registers are taken
// on any cycle with cfg_we high and should be written only while no beat is
// in flight; writes take effect on the next beat.
module belt_drive_ramp_state_machine (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port: 0 max_speed, 1 max_incline, 2 speed_rate,
    // 3 incline_rate.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[15:0], dir_in[16], dt_ms[24:17], zero fill
    input  logic [2:0]  s_tuser,   // operation[2:0]

    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // accepted[0], error_code[2:1], run_state_out[4:3],
                                   // speed_out[20:5], incline_out[36:21], dir_out[37],
                                   // zero fill
);

    logic [bdr_pkg::CFG_W-1:0]  max_speed_reg;
    logic [bdr_pkg::CFG_W-1:0]  max_incline_reg;
    logic [bdr_pkg::CFG_W-1:0]  speed_rate_reg;
    logic [bdr_pkg::CFG_W-1:0]  incline_rate_reg;

    // Input register.
    logic                       in_valid_reg;
    bdr_pkg::item_t             in_item_reg;
    bdr_pkg::item_t             in_item_next;
    logic [bdr_pkg::DT_W-1:0]   in_dt_reg;
    logic                       in_load;

    logic                       step_in_ready;
    logic                       step_valid;
    bdr_pkg::step_item_t        step_item;
    logic                       core_in_ready;
    bdr_pkg::result_t           result;

    // Configuration registers; an address past the list cannot occur with a
    // two bit index, and every index maps to a register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg    <= bdr_pkg::MAX_SPEED_RST;
            max_incline_reg  <= bdr_pkg::MAX_INCLINE_RST;
            speed_rate_reg   <= bdr_pkg::SPEED_RATE_RST;
            incline_rate_reg <= bdr_pkg::INCLINE_RATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bdr_pkg::REG_MAX_SPEED:    max_speed_reg    <= cfg_wdata;
                bdr_pkg::REG_MAX_INCLINE:  max_incline_reg  <= cfg_wdata;
                bdr_pkg::REG_SPEED_RATE:   speed_rate_reg   <= cfg_wdata;
                bdr_pkg::REG_INCLINE_RATE: incline_rate_reg <= cfg_wdata;
                default:                   max_speed_reg    <= max_speed_reg;
            endcase
        end
    end

    // The input register empties whenever the multiply stage takes its beat,
    // so a new beat can land in the same cycle.
    assign s_tready = !in_valid_reg || step_in_ready;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_item_next.op    = bdr_pkg::op_t'(s_tuser);
        in_item_next.value = s_tdata[15:0];
        in_item_next.dir   = s_tdata[16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (step_in_ready) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= in_item_next;
            in_dt_reg   <= s_tdata[24:17];
        end
    end

    bdr_step_unit u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .speed_rate   (speed_rate_reg),
        .incline_rate (incline_rate_reg),
        .in_valid     (in_valid_reg),
        .in_ready     (step_in_ready),
        .in_item      (in_item_reg),
        .in_dt        (in_dt_reg),
        .out_valid    (step_valid),
        .out_ready    (core_in_ready),
        .out_item     (step_item)
    );

    bdr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_speed   (max_speed_reg),
        .max_incline (max_incline_reg),
        .in_valid    (step_valid),
        .in_ready    (core_in_ready),
        .in_item     (step_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (result)
    );

    // Pack the result fields, lowest bit first.
    assign m_tdata = {2'b00,
                      result.dir,
                      result.incline,
                      result.speed,
                      result.run_state,
                      result.error_code,
                      result.accepted};

endmodule
